// ===== rtl/sch_pkg.sv =====
package sch_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int RAD_W    = 23;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DOT_W    = SQ_W + 2;
    localparam int RSUM_W   = RAD_W + 1;
    localparam int RR_W     = 2 * RSUM_W;
    localparam int HALF_W   = SQ_W / 2;
    localparam int PP_W     = 2 * HALF_W;
    localparam int PROD_W   = 2 * SQ_W;

    // stream packing
    localparam int S_FIELDS_W = 9 * COORD_W + 2 * RAD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // tdata offsets, lowest bit of each field
    localparam int OFS_SPHERE_X  = 0;
    localparam int OFS_SPHERE_Y  = OFS_SPHERE_X + COORD_W;
    localparam int OFS_SPHERE_Z  = OFS_SPHERE_Y + COORD_W;
    localparam int OFS_SPHERE_R  = OFS_SPHERE_Z + COORD_W;
    localparam int OFS_START_X   = OFS_SPHERE_R + RAD_W;
    localparam int OFS_START_Y   = OFS_START_X + COORD_W;
    localparam int OFS_START_Z   = OFS_START_Y + COORD_W;
    localparam int OFS_FINISH_X  = OFS_START_Z + COORD_W;
    localparam int OFS_FINISH_Y  = OFS_FINISH_X + COORD_W;
    localparam int OFS_FINISH_Z  = OFS_FINISH_Y + COORD_W;
    localparam int OFS_CAPSULE_R = OFS_FINISH_Z + COORD_W;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SQ_W-1:0]   sprod_t;
    typedef logic        [SQ_W-1:0]   sq_t;
    typedef logic        [PP_W-1:0]   pp_t;
    typedef logic        [PROD_W-1:0] prod_t;

    // outcome flags of the clamp decision
    typedef struct packed {
        logic near_start;
        logic far_end;
        logic hit_start;
        logic hit_finish;
    } clamp_t;

endpackage

// ===== rtl/sphere_capsule_hit_test.sv =====
// channel | dir | handshake         | tdata fields (low bit up)
// s_      | in  | s_tvalid/s_tready | sphere xyz, sphere radius, start xyz, finish xyz, capsule r
// m_      | out | m_tvalid/m_tready | hit
//
// one item per cycle sustained while m_tready is high or the output stage is empty
// the multiplier stages are the squares, then split 25 by 25 partial products
// aresetn (synchronous) clears the valid bits of every stage
// m_tready low freezes the whole pipeline once the output stage holds an item;
// nothing is dropped or repeated
module sphere_capsule_hit_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, start_x, start_y, start_z,
    // finish_x, finish_y, finish_z, capsule_radius, zero pad
    input  logic [sch_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, zero pad
    output logic [sch_pkg::M_TDATA_W-1:0] m_tdata
);
    import sch_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    // stage 1 regs
    diff_t w_reg [3];
    diff_t d_reg [3];
    diff_t e_reg [3];
    logic [RSUM_W-1:0] rsum_reg;

    // stage 2 regs
    sq_t    ww_reg [3];
    sq_t    dd_reg [3];
    sq_t    ee_reg [3];
    sprod_t dw_reg [3];
    logic [RR_W-1:0] rr2_reg;

    // stage 3 regs
    sq_t w2_reg, len2_reg, e2_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [RR_W-1:0] rr3_reg;

    // stage 4 regs
    clamp_t c4_reg;
    sq_t    diff4_reg, len4_reg, dotu4_reg;

    // stage 5 regs
    clamp_t c5_reg;
    pp_t    a_ll_reg, a_lh_reg, a_hl_reg, a_hh_reg;
    pp_t    b_ll_reg, b_lh_reg, b_hh_reg;

    // stage 6 regs
    clamp_t c6_reg;
    prod_t  lhs_reg, rhs_reg;

    logic hit_reg;

    assign en       = !v7_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = v7_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, hit_reg};

    // input field extraction
    logic signed [COORD_W-1:0] p_in [3];
    logic signed [COORD_W-1:0] a_in [3];
    logic signed [COORD_W-1:0] b_in [3];
    logic [RAD_W-1:0] rs_in, rc_in;

    always_comb begin
        p_in[0] = s_tdata[OFS_SPHERE_X +: COORD_W];
        p_in[1] = s_tdata[OFS_SPHERE_Y +: COORD_W];
        p_in[2] = s_tdata[OFS_SPHERE_Z +: COORD_W];
        a_in[0] = s_tdata[OFS_START_X +: COORD_W];
        a_in[1] = s_tdata[OFS_START_Y +: COORD_W];
        a_in[2] = s_tdata[OFS_START_Z +: COORD_W];
        b_in[0] = s_tdata[OFS_FINISH_X +: COORD_W];
        b_in[1] = s_tdata[OFS_FINISH_Y +: COORD_W];
        b_in[2] = s_tdata[OFS_FINISH_Z +: COORD_W];
        rs_in   = s_tdata[OFS_SPHERE_R +: RAD_W];
        rc_in   = s_tdata[OFS_CAPSULE_R +: RAD_W];
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 1: difference vectors and radius sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                w_reg[i] <= DIFF_W'(p_in[i]) - DIFF_W'(a_in[i]);
                d_reg[i] <= DIFF_W'(b_in[i]) - DIFF_W'(a_in[i]);
                e_reg[i] <= DIFF_W'(p_in[i]) - DIFF_W'(b_in[i]);
            end
            rsum_reg <= RSUM_W'(rs_in) + RSUM_W'(rc_in);
        end
    end

    // stage 2: squares and axis products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ww_reg[i] <= sq_t'(w_reg[i] * w_reg[i]);
                dd_reg[i] <= sq_t'(d_reg[i] * d_reg[i]);
                ee_reg[i] <= sq_t'(e_reg[i] * e_reg[i]);
                dw_reg[i] <= d_reg[i] * w_reg[i];
            end
            rr2_reg <= rsum_reg * rsum_reg;
        end
    end

    // stage 3: sums of three
    always_ff @(posedge aclk) begin
        if (en) begin
            w2_reg   <= ww_reg[0] + ww_reg[1] + ww_reg[2];
            len2_reg <= dd_reg[0] + dd_reg[1] + dd_reg[2];
            e2_reg   <= ee_reg[0] + ee_reg[1] + ee_reg[2];
            dot_reg  <= DOT_W'(dw_reg[0]) + DOT_W'(dw_reg[1]) + DOT_W'(dw_reg[2]);
            rr3_reg  <= rr2_reg;
        end
    end

    // stage 4: clamp decision and inside-segment operands
    clamp_t c4_next;
    sq_t    rr_ext;

    always_comb begin
        rr_ext             = SQ_W'(rr3_reg);
        c4_next.near_start = (len2_reg == '0) || (dot_reg <= 0);
        c4_next.far_end    = dot_reg >= $signed({2'b00, len2_reg});
        c4_next.hit_start  = w2_reg < rr_ext;
        c4_next.hit_finish = e2_reg < rr_ext;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c4_reg    <= c4_next;
            diff4_reg <= c4_next.hit_start ? '0 : w2_reg - rr_ext;
            len4_reg  <= len2_reg;
            dotu4_reg <= dot_reg[SQ_W-1:0];
        end
    end

    // stage 5: partial products of the split operands
    always_ff @(posedge aclk) begin
        if (en) begin
            c5_reg   <= c4_reg;
            a_ll_reg <= diff4_reg[HALF_W-1:0] * len4_reg[HALF_W-1:0];
            a_lh_reg <= diff4_reg[HALF_W-1:0] * len4_reg[SQ_W-1:HALF_W];
            a_hl_reg <= diff4_reg[SQ_W-1:HALF_W] * len4_reg[HALF_W-1:0];
            a_hh_reg <= diff4_reg[SQ_W-1:HALF_W] * len4_reg[SQ_W-1:HALF_W];
            b_ll_reg <= dotu4_reg[HALF_W-1:0] * dotu4_reg[HALF_W-1:0];
            b_lh_reg <= dotu4_reg[HALF_W-1:0] * dotu4_reg[SQ_W-1:HALF_W];
            b_hh_reg <= dotu4_reg[SQ_W-1:HALF_W] * dotu4_reg[SQ_W-1:HALF_W];
        end
    end

    // stage 6: recombine the wide products
    always_ff @(posedge aclk) begin
        if (en) begin
            c6_reg  <= c5_reg;
            lhs_reg <= (PROD_W'(a_hh_reg) << SQ_W)
                     + (PROD_W'(a_lh_reg) << HALF_W)
                     + (PROD_W'(a_hl_reg) << HALF_W)
                     + PROD_W'(a_ll_reg);
            rhs_reg <= (PROD_W'(b_hh_reg) << SQ_W)
                     + (PROD_W'(b_lh_reg) << (HALF_W + 1))
                     + PROD_W'(b_ll_reg);
        end
    end

    // stage 7: final compare into the output register
    logic hit_next;

    always_comb begin
        priority if (c6_reg.near_start) begin
            hit_next = c6_reg.hit_start;
        end else if (c6_reg.far_end) begin
            hit_next = c6_reg.hit_finish;
        end else if (c6_reg.hit_start) begin
            hit_next = 1'b1;
        end else begin
            hit_next = lhs_reg < rhs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

endmodule
